### rtl/psp_pkg.sv
`timescale 1ns / 1ps
// psp_pkg: shared constants for the pixel shuffle / premultiply block
// no dependencies; imported by psp_lane, pixel_shuffle_premultiply and psp_checker

package psp_pkg;

  // byte lane geometry
  localparam int unsigned LANE_W   = 8;
  localparam int unsigned NUM_LANE = 4;
  localparam int unsigned PIXEL_W  = LANE_W * NUM_LANE;

  // register map
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_PREMUL    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ALPHA     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SEL0      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SEL1      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SEL2      = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_SEL3      = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_FILL_MASK = 3'd6;

  // byte selector: codes 0..3 pick a source byte, anything above gives zero
  localparam int unsigned SEL_W    = 3;
  localparam logic [SEL_W-1:0] SEL_LAST_BYTE = 3'd3;

  // rounding constant for c*a/255
  localparam logic [2*LANE_W-1:0] ROUND_HALF = 16'd128;

  typedef logic [LANE_W-1:0] lane_t;
  typedef logic [SEL_W-1:0]  sel_t;

endpackage

### rtl/psp_lane.sv
`timescale 1ns / 1ps
// psp_lane: one colour byte scaled by alpha with rounding, c*a/255, or passed through when scale_en is low
// depends on psp_pkg

module psp_lane
  import psp_pkg::*;
(
  input  lane_t colour,
  input  lane_t alpha,
  input  logic  scale_en,
  output lane_t result
);

  logic [2*LANE_W-1:0] prod;
  logic [2*LANE_W-1:0] rnd;
  logic [2*LANE_W:0]   folded;

  // t = c*a + 128, then (t + (t >> 8)) >> 8
  assign prod   = {{LANE_W{1'b0}}, colour} * {{LANE_W{1'b0}}, alpha};
  assign rnd    = prod + ROUND_HALF;
  assign folded = {1'b0, rnd} + {{(LANE_W+1){1'b0}}, rnd[2*LANE_W-1:LANE_W]};

  assign result = scale_en ? folded[2*LANE_W-1:LANE_W] : colour;

endmodule

### rtl/pixel_shuffle_premultiply.sv
`timescale 1ns / 1ps
// pixel_shuffle_premultiply: top level, byte shuffle with optional alpha premultiply
// depends on psp_pkg and psp_lane
//
//   channel   direction  beat contents (low bit up)
//   in_       slave      tdata[31:0] in_pixel
//   out_      master     tdata[31:0] out_pixel
//   cfg_      write      cfg_addr selects register 0..6, cfg_wdata[31:0]
//
// one pixel per clock while out_tready is high; a beat is registered in in_pixel_r, then out_pixel_r
// the input register feeds shuffle, one 8x8 multiply per lane and the mask OR,
// which land in the result register
// rst_n is synchronous and active low; it empties both stages and loads register defaults
// a stalled result holds; a new beat is still taken while the input stage can move on

module pixel_shuffle_premultiply
  import psp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // source stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIXEL_W-1:0]    in_tdata,   // [31:0] in_pixel
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [PIXEL_W-1:0]    out_tdata,  // [31:0] out_pixel
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  logic               premul_on_r;
  logic [1:0]         alpha_lane_r;
  sel_t               sel_r [NUM_LANE];
  logic [PIXEL_W-1:0] fill_mask_r;

  // pipeline stages
  logic               in_vld_r;
  logic [PIXEL_W-1:0] in_pixel_r;
  logic               out_vld_r;
  logic [PIXEL_W-1:0] out_pixel_r;
  logic [PIXEL_W-1:0] out_pixel_nxt;

  logic  out_adv;
  logic  in_adv;
  lane_t shuf   [NUM_LANE];
  lane_t scaled [NUM_LANE];
  lane_t alpha;

  // register writes, indexes past the map are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      premul_on_r  <= 1'b1;
      alpha_lane_r <= 2'd3;
      sel_r[0]     <= 3'd0;
      sel_r[1]     <= 3'd1;
      sel_r[2]     <= 3'd2;
      sel_r[3]     <= 3'd3;
      fill_mask_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PREMUL:    premul_on_r  <= cfg_wdata[0];
        REG_ALPHA:     alpha_lane_r <= cfg_wdata[1:0];
        REG_SEL0:      sel_r[0]     <= cfg_wdata[SEL_W-1:0];
        REG_SEL1:      sel_r[1]     <= cfg_wdata[SEL_W-1:0];
        REG_SEL2:      sel_r[2]     <= cfg_wdata[SEL_W-1:0];
        REG_SEL3:      sel_r[3]     <= cfg_wdata[SEL_W-1:0];
        REG_FILL_MASK: fill_mask_r  <= cfg_wdata[PIXEL_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: result stage frees when empty or taken, input stage follows
  assign out_adv    = !out_vld_r || out_tready;
  assign in_adv     = in_vld_r && out_adv;
  assign in_tready  = !in_vld_r || out_adv;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_pixel_r;

  // byte shuffle
  always_comb begin
    for (int j = 0; j < NUM_LANE; j++) begin
      if (sel_r[j] > SEL_LAST_BYTE) begin
        shuf[j] = '0;
      end else begin
        shuf[j] = in_pixel_r[sel_r[j][1:0]*LANE_W +: LANE_W];
      end
    end
  end

  assign alpha = shuf[alpha_lane_r];

  // premultiply every lane but the alpha lane when premul_on_r is set
  for (genvar g = 0; g < NUM_LANE; g++) begin : g_lane
    psp_lane u_lane (
      .colour   (shuf[g]),
      .alpha    (alpha),
      .scale_en (premul_on_r && (alpha_lane_r != 2'(g))),
      .result   (scaled[g])
    );
  end

  assign out_pixel_nxt = {scaled[3], scaled[2], scaled[1], scaled[0]} | fill_mask_r;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (out_adv) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_pixel_r <= in_tdata;
    end
    if (in_adv) begin
      out_pixel_r <= out_pixel_nxt;
    end
  end

endmodule

### rtl/psp_checker.sv
`timescale 1ns / 1ps
// psp_checker: port-level checks on pixel_shuffle_premultiply, bound to the top level
// depends on psp_pkg

module psp_checker
  import psp_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [PIXEL_W-1:0] out_tdata
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a ready sink never stalls the source
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input not ready while result side is ready");

  // an accepted beat reaches the output when the sink is ready as it leaves the input register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready |=> out_tvalid)
    else $error("accepted beat did not reach the output");

endmodule

bind pixel_shuffle_premultiply psp_checker u_psp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
